// File: rtl/u8dec_pkg.sv
package u8dec_pkg;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] TAG_LEAD2   = 8'hC0;
    localparam logic [7:0] MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] TAG_LEAD3   = 8'hE0;
    localparam logic [7:0] MASK_LEAD4  = 8'hF8;
    localparam logic [7:0] TAG_LEAD4   = 8'hF0;
    localparam logic [7:0] MASK_CONT   = 8'h3F;
    localparam logic [7:0] MASK_BITS2  = 8'h1F;
    localparam logic [7:0] MASK_BITS3  = 8'h0F;
    localparam logic [7:0] MASK_BITS4  = 8'h07;

    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        last_of_run;
    } out_beat_t;

    // finite string of one to four bytes handed to the back end
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } job_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < ASCII_LIMIT)
            len = LEN_ONE;
        else if ((b & MASK_LEAD2) == TAG_LEAD2)
            len = LEN_TWO;
        else if ((b & MASK_LEAD3) == TAG_LEAD3)
            len = LEN_THREE;
        else if ((b & MASK_LEAD4) == TAG_LEAD4)
            len = LEN_FOUR;
        else
            len = LEN_ONE;
        return len;
    endfunction

endpackage

// File: rtl/u8dec_front.sv
module u8dec_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  u8dec_pkg::in_beat_t beat,
    output logic                push,
    output u8dec_pkg::job_t     job
);

    logic [2:0][7:0] pend_reg, pend_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0]      need_reg, need_next;

    logic [1:0] cnt_eff;
    logic [2:0] m;
    logic [2:0] len;
    logic       hold;

    always_comb
    begin
        cnt_eff = (need_reg == 3'd0) ? 2'd0 : cnt_reg;
        m       = {1'b0, cnt_eff} + 3'd1;
        len     = u8dec_pkg::seq_len(beat.in_byte);
        hold    = !beat.end_of_text &&
                  (((need_reg == 3'd0) && (len > u8dec_pkg::LEN_ONE)) ||
                   ((need_reg != 3'd0) && (m < need_reg)));

        // pending bytes first, then the new byte
        for (int j = 0; j < 4; j++)
        begin
            if (j < 3 && j < int'(cnt_eff))
                job.bytes[j] = pend_reg[j];
            else if (j == int'(cnt_eff))
                job.bytes[j] = beat.in_byte;
            else
                job.bytes[j] = 8'h00;
        end
        job.count = m;
        push      = accept && !hold;

        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        need_next = need_reg;
        if (accept)
        begin
            if (hold)
            begin
                if (need_reg == 3'd0)
                begin
                    pend_next[0] = beat.in_byte;
                    cnt_next     = 2'd1;
                    need_next    = len;
                end
                else
                begin
                    pend_next[cnt_eff] = beat.in_byte;
                    cnt_next           = m[1:0];
                end
            end
            else
            begin
                pend_next = '0;
                cnt_next  = 2'd0;
                need_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= 2'd0;
            need_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            need_reg <= need_next;
        end
    end

endmodule

// File: rtl/u8dec_queue.sv
module u8dec_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u8dec_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output u8dec_pkg::job_t head_job
);

    u8dec_pkg::job_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;

    always_comb
    begin
        full        = (fill_reg == 2'd2);
        not_empty   = (fill_reg != 2'd0);
        head_job    = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (!push && pop)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: rtl/u8dec_back.sv
module u8dec_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  u8dec_pkg::job_t      job,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output u8dec_pkg::out_beat_t out_beat
);

    logic [1:0]           pos_reg, pos_next;
    logic                 valid_reg, valid_next;
    u8dec_pkg::out_beat_t beat_reg, beat_next;

    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  rem, len, step, nxt;
    logic        whole, done, load;
    logic [20:0] cp;

    always_comb
    begin
        b0    = job.bytes[pos_reg];
        b1    = job.bytes[pos_reg + 2'd1];
        b2    = job.bytes[pos_reg + 2'd2];
        b3    = job.bytes[pos_reg + 2'd3];
        rem   = job.count - {1'b0, pos_reg};
        len   = u8dec_pkg::seq_len(b0);
        whole = (len > u8dec_pkg::LEN_ONE) && (rem >= len);

        cp = {13'd0, b0};
        if (whole)
        begin
            case (len)
                u8dec_pkg::LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
                u8dec_pkg::LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                u8dec_pkg::LEN_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                default:              cp = {13'd0, b0};
            endcase
        end

        step = whole ? len : u8dec_pkg::LEN_ONE;
        nxt  = {1'b0, pos_reg} + step;
        done = (nxt >= job.count);
        load = job_valid && (!valid_reg || !out_stall);
        pop  = load && done;

        pos_next   = pos_reg;
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (load)
        begin
            pos_next              = done ? 2'd0 : nxt[1:0];
            valid_next            = 1'b1;
            beat_next.code_point  = cp;
            beat_next.last_of_run = done;
        end
        else if (!out_stall)
            valid_next = 1'b0;

        out_valid = valid_reg;
        out_beat  = beat_reg;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: rtl/utf8_byte_stream_decoder_top.sv
// a result beat passes the job queue and then the output register after the byte closing its string is taken
// throughput: one byte per cycle while the job queue is not full; the back end emits one code
// point per cycle unless stalled, and a byte may release up to three code points on a cut-off tail
// reset: rst_n clears pending sequence state, the two-entry job queue and the output valid flag
module utf8_byte_stream_decoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  u8dec_pkg::in_beat_t  byte_data,
    output logic                 cp_valid,
    input  logic                 cp_stall,
    output u8dec_pkg::out_beat_t cp_data
);

    // front end: collects multi-byte sequences, hands each closed string on as a job
    // back end: walks a job one code point per cycle into the output register while the output is not stalled
    logic            accept;
    logic            push;
    u8dec_pkg::job_t push_job;
    logic            q_full;
    logic            pop;
    logic            q_not_empty;
    u8dec_pkg::job_t head_job;

    // bytes wait only while the job queue is full
    assign byte_stall = q_full;
    assign accept     = byte_valid && !byte_stall;

    u8dec_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (byte_data),
        .push   (push),
        .job    (push_job)
    );

    // short queue lets the front keep taking bytes while a long job drains
    u8dec_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    u8dec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (head_job),
        .pop       (pop),
        .out_valid (cp_valid),
        .out_stall (cp_stall),
        .out_beat  (cp_data)
    );

endmodule

// File: sim/utf8_byte_stream_decoder_top_tb.sv
module utf8_byte_stream_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any beat on either side before the run is declared hung
    localparam int unsigned HANG_LIMIT   = 2000;
    // the block's result beats pass the job queue and the output register after the closing byte
    localparam int unsigned SETTLE_TICKS = 8;
    localparam int unsigned RANDOM_BYTES = 260;

    // expected code points, worked out from the byte stream as it is accepted
    class code_point_board;
        u8dec_pkg::out_beat_t cp_due[$];
        logic [7:0]           held_bytes[3];
        int unsigned          held_count;
        int unsigned          open_len;
        int unsigned          errors;
        int unsigned          bytes_seen;
        int unsigned          cps_seen;

        function new();
            errors     = 0;
            bytes_seen = 0;
            cps_seen   = 0;
            drop_sequence();
        endfunction

        function void drop_sequence();
            held_bytes = '{default: 8'h00};
            held_count = 0;
            open_len   = 0;
        endfunction

        function int unsigned lead_length(logic [7:0] b);
            if (b < u8dec_pkg::ASCII_LIMIT)
                return 32'(u8dec_pkg::LEN_ONE);
            if ((b & u8dec_pkg::MASK_LEAD2) == u8dec_pkg::TAG_LEAD2)
                return 32'(u8dec_pkg::LEN_TWO);
            if ((b & u8dec_pkg::MASK_LEAD3) == u8dec_pkg::TAG_LEAD3)
                return 32'(u8dec_pkg::LEN_THREE);
            if ((b & u8dec_pkg::MASK_LEAD4) == u8dec_pkg::TAG_LEAD4)
                return 32'(u8dec_pkg::LEN_FOUR);
            return 32'(u8dec_pkg::LEN_ONE);
        endfunction

        function void take_byte(u8dec_pkg::in_beat_t beat);
            logic [7:0]           str[4];
            logic [20:0]          cps[$];
            logic [20:0]          cp;
            logic [7:0]           b0;
            u8dec_pkg::out_beat_t exp_beat;
            int unsigned          n;
            int unsigned          i;
            int unsigned          len;
            bytes_seen++;
            n = 0;
            if (open_len != 0)
            begin
                for (i = 0; i < held_count; i++)
                begin
                    str[n] = held_bytes[i];
                    n++;
                end
            end
            str[n] = beat.in_byte;
            n++;

            if (!beat.end_of_text)
            begin
                if (open_len == 0)
                begin
                    len = lead_length(beat.in_byte);
                    if (len > 1)
                    begin
                        held_bytes[0] = beat.in_byte;
                        held_count    = 1;
                        open_len      = len;
                        return;
                    end
                end
                else if (n < open_len)
                begin
                    // still collecting, nothing leaves yet
                    held_bytes[n - 1] = beat.in_byte;
                    held_count        = n;
                    return;
                end
            end

            // decode the collected bytes as a finite string
            i = 0;
            while (i < n)
            begin
                b0  = str[i];
                len = lead_length(b0);
                if (len > 1 && n - i >= len)
                begin
                    case (len)
                        32'(u8dec_pkg::LEN_TWO):
                            cp = (21'(b0 & u8dec_pkg::MASK_BITS2) << 6)
                               | 21'(str[i + 1] & u8dec_pkg::MASK_CONT);
                        32'(u8dec_pkg::LEN_THREE):
                            cp = (21'(b0 & u8dec_pkg::MASK_BITS3) << 12)
                               | (21'(str[i + 1] & u8dec_pkg::MASK_CONT) << 6)
                               | 21'(str[i + 2] & u8dec_pkg::MASK_CONT);
                        default:
                            cp = (21'(b0 & u8dec_pkg::MASK_BITS4) << 18)
                               | (21'(str[i + 1] & u8dec_pkg::MASK_CONT) << 12)
                               | (21'(str[i + 2] & u8dec_pkg::MASK_CONT) << 6)
                               | 21'(str[i + 3] & u8dec_pkg::MASK_CONT);
                    endcase
                    i += len;
                end
                else
                begin
                    cp = 21'(b0);
                    i++;
                end
                cps = {cps, cp};
            end
            foreach (cps[j])
            begin
                exp_beat.code_point  = cps[j];
                exp_beat.last_of_run = (j == cps.size() - 1);
                cp_due = {cp_due, exp_beat};
            end
            drop_sequence();
        endfunction

        function void check_code_point(u8dec_pkg::out_beat_t got);
            u8dec_pkg::out_beat_t want;
            cps_seen++;
            if (cp_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected code point beat: expected none, actual cp=%h last=%b",
                         $time, got.code_point, got.last_of_run);
                return;
            end
            want = cp_due.pop_front();
            if (got.code_point !== want.code_point)
            begin
                errors++;
                $display("%0t: code_point mismatch: expected %h, actual %h",
                         $time, want.code_point, got.code_point);
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                errors++;
                $display("%0t: last_of_run mismatch: expected %b, actual %b",
                         $time, want.last_of_run, got.last_of_run);
            end
        endfunction
    endclass

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 byte_valid = 1'b0;
    logic                 byte_stall;
    u8dec_pkg::in_beat_t  byte_data  = '0;
    logic                 cp_valid;
    logic                 cp_stall   = 1'b0;
    u8dec_pkg::out_beat_t cp_data;

    // when set, neither side idles
    logic      calm = 1'b0;

    code_point_board board = new();

    int unsigned sent_bytes    = 0;
    int unsigned whole_seqs    = 0;
    int unsigned cut_seqs      = 0;
    int unsigned loose_bytes   = 0;

    utf8_byte_stream_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .cp_valid   (cp_valid),
        .cp_stall   (cp_stall),
        .cp_data    (cp_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one byte beat: optional idle gap, then hold until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic eot);
        u8dec_pkg::in_beat_t beat;
        int unsigned         gap;
        beat.in_byte     = b;
        beat.end_of_text = eot;
        gap = 0;
        if (!calm)
        begin
            while ($urandom_range(99) < 25)
                gap++;
        end
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= beat;
        do
            @(posedge clk);
        while (byte_stall);
        board.take_byte(beat);
        sent_bytes++;
    endtask

    function automatic logic [7:0] random_lead(int unsigned len);
        case (len)
            32'(u8dec_pkg::LEN_TWO):   return u8dec_pkg::TAG_LEAD2 | 8'($urandom_range(31));
            32'(u8dec_pkg::LEN_THREE): return u8dec_pkg::TAG_LEAD3 | 8'($urandom_range(15));
            32'(u8dec_pkg::LEN_FOUR):  return u8dec_pkg::TAG_LEAD4 | 8'($urandom_range(7));
            default:                   return 8'($urandom_range(127));
        endcase
    endfunction

    // well-formed sequence with random payload, now and then a wrong tag
    task automatic send_whole_sequence();
        int unsigned len;
        logic [7:0]  b;
        logic        eot_at_end;
        len        = $urandom_range(1, 4);
        eot_at_end = ($urandom_range(99) < 10);
        send_byte(random_lead(len), eot_at_end && len == 1);
        for (int unsigned i = 1; i < len; i++)
        begin
            if ($urandom_range(99) < 15)
                b = 8'($urandom_range(255));
            else
                b = 8'h80 | 8'($urandom_range(63));
            send_byte(b, eot_at_end && i == len - 1);
        end
        whole_seqs++;
    endtask

    // lead followed by too few bytes, the last one closing the string
    task automatic send_cut_sequence();
        int unsigned len;
        int unsigned cnt;
        logic [7:0]  b;
        len = $urandom_range(2, 4);
        cnt = $urandom_range(1, len - 1);
        send_byte(random_lead(len), cnt == 1);
        for (int unsigned i = 1; i < cnt; i++)
        begin
            // mix in arbitrary bytes so leads show up inside the tail
            if ($urandom_range(1) == 1)
                b = 8'($urandom_range(255));
            else
                b = 8'h80 | 8'($urandom_range(63));
            send_byte(b, i == cnt - 1);
        end
        cut_seqs++;
    endtask

    // result side: check every accepted beat, stall at random
    always @(posedge clk)
    begin
        if (rst_n && cp_valid && !cp_stall)
            board.check_code_point(cp_data);
        cp_stall <= !calm && ($urandom_range(99) < 25);
    end

    // hang detector: counts cycles with no beat moving on either side
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (cp_valid && !cp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, HANG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and each special case
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h41, 1'b1);     // plain byte closing the string
        send_byte(8'h80, 1'b0);     // stray continuation
        send_byte(8'hFF, 1'b1);     // no lead, all ones
        send_byte(8'hC2, 1'b0);     // two byte sequence
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);     // three byte sequence
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);     // four byte, largest value
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC3, 1'b1);     // lead as last byte of the string
        send_byte(8'hC3, 1'b0);     // wrong tag on the continuation
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);     // three byte cut after two
        send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b0);     // cut four byte, tail holds a full pair
        send_byte(8'hC2, 1'b0);
        send_byte(8'hE0, 1'b1);
        send_byte(8'hF0, 1'b0);     // cut four byte, three raw results
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);

        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            calm = (sent_bytes >= 60 && sent_bytes < 120);
            if (sent_bytes >= 130 && sent_bytes < 136 && board.cp_due.size() != 0)
            begin
                // hold off input until the block has drained
                byte_valid <= 1'b0;
                while (board.cp_due.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(99);
            if (pick < 65)
                send_whole_sequence();
            else if (pick < 80)
                send_cut_sequence();
            else
            begin
                send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
                loose_bytes++;
            end
        end
        calm = 1'b0;
        byte_valid <= 1'b0;

        while (board.cp_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("covered %0d bytes: %0d whole sequences, %0d cut-off strings, %0d loose bytes",
                 board.bytes_seen, whole_seqs, cut_seqs, loose_bytes);
        $display("checked %0d code point beats, %0d mismatches",
                 board.cps_seen, board.errors);
        if (board.errors == 0 && board.cp_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/u8dec_pkg.sv
rtl/u8dec_front.sv
rtl/u8dec_queue.sv
rtl/u8dec_back.sv
rtl/utf8_byte_stream_decoder_top.sv
sim/utf8_byte_stream_decoder_top_tb.sv
